FILE: hw/rtl/signal_channel_state_merge_defines.svh
// Assertion macros for the signal channel state merge block
`ifndef SIGNAL_CHANNEL_STATE_MERGE_DEFINES_SVH
`define SIGNAL_CHANNEL_STATE_MERGE_DEFINES_SVH

// Check a property outside reset
`define SCSM_ASSERT(label, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("scsm assertion failed");

// Check a property on every clock edge, reset included
`define SCSM_ASSERT_ALWAYS(label, prop) \
  label: assert property (@(posedge clk) prop) \
    else $error("scsm assertion failed");

`endif

FILE: hw/rtl/scsm_pkg.sv
package scsm_pkg;

  // Field widths
  localparam int unsigned CHANNELS_DEF = 32;
  localparam int unsigned MASK_W       = 32;
  localparam int unsigned LAMP_W       = 3;
  localparam int unsigned ST_W         = 4;
  localparam int unsigned CD_W         = 16;
  localparam int unsigned IDX_W        = 5;
  localparam int unsigned SECS_W       = 8;
  localparam int unsigned CFG_IDX_W    = 1;
  localparam int unsigned CFG_DATA_W   = 8;

  // Opcodes
  localparam logic OP_MERGE = 1'b0;
  localparam logic OP_FLUSH = 1'b1;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_YELLOW_FLASH = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_RED_FLASH    = 1'b1;

  // Lamp state codes
  localparam logic [ST_W-1:0] ST_INVALID      = 4'd0;
  localparam logic [ST_W-1:0] ST_GREEN        = 4'd1;
  localparam logic [ST_W-1:0] ST_GREEN_BLINK  = 4'd2;
  localparam logic [ST_W-1:0] ST_YELLOW       = 4'd3;
  localparam logic [ST_W-1:0] ST_RED_YELLOW   = 4'd4;
  localparam logic [ST_W-1:0] ST_ALL_RED      = 4'd5;
  localparam logic [ST_W-1:0] ST_RED          = 4'd6;
  localparam logic [ST_W-1:0] ST_YELLOW_BLINK = 4'd7;
  localparam logic [ST_W-1:0] ST_RED_BLINK    = 4'd8;

  typedef enum logic {
    FS_IDLE,
    FS_FLUSH
  } flush_state_t;

  // Offer broadcast to every cell
  typedef struct packed {
    logic [ST_W-1:0] offer_st;
    logic [ST_W-1:0] store_st;
    logic [CD_W-1:0] secs;
  } offer_t;

  typedef struct packed {
    logic merge;
    logic shift;
  } cell_ctrl_t;

  typedef struct packed {
    logic             busy;
    logic             valid;
    logic             last;
    logic [IDX_W-1:0] index;
  } flush_stat_t;

  // Priority rule: does a channel holding cur/cnt take offer nst/t
  function automatic logic offer_taken(input logic [ST_W-1:0] cur,
                                       input logic [CD_W-1:0] cnt,
                                       input logic [ST_W-1:0] nst,
                                       input logic [CD_W-1:0] t);
    logic taken;
    taken = 1'b0;
    if (cur == nst) begin
      if (nst inside {ST_GREEN, ST_GREEN_BLINK, ST_YELLOW, ST_RED_YELLOW}) begin
        taken = (cnt < t);
      end else if (nst inside {ST_ALL_RED, ST_RED}) begin
        taken = (cnt > t);
      end
    end else begin
      case (cur)
        ST_INVALID, ST_RED: taken = 1'b1;
        ST_ALL_RED:         taken = (nst != ST_RED);
        ST_RED_YELLOW:      taken = nst inside {ST_YELLOW, ST_GREEN_BLINK, ST_GREEN};
        ST_YELLOW:          taken = nst inside {ST_GREEN_BLINK, ST_GREEN};
        ST_GREEN_BLINK:     taken = (nst == ST_GREEN);
        default:            taken = 1'b0;
      endcase
    end
    return taken;
  endfunction

endpackage

FILE: hw/rtl/scsm_in_if.sv
interface scsm_in_if;
  logic                          valid;
  logic                          ready;
  logic                          opcode;
  logic [scsm_pkg::MASK_W-1:0]   channel_mask;
  logic [scsm_pkg::LAMP_W-1:0]   lamp_state;
  logic [scsm_pkg::CD_W-1:0]     seconds_left;

  modport source (output valid, opcode, channel_mask, lamp_state, seconds_left,
                  input ready);
  modport sink (input valid, opcode, channel_mask, lamp_state, seconds_left,
                output ready);
endinterface

FILE: hw/rtl/scsm_out_if.sv
interface scsm_out_if;
  logic                        valid;
  logic                        ready;
  logic [scsm_pkg::IDX_W-1:0]  channel_index;
  logic [scsm_pkg::ST_W-1:0]   channel_state;
  logic [scsm_pkg::CD_W-1:0]   channel_countdown;
  logic                        last_of_frame;

  modport source (output valid, channel_index, channel_state, channel_countdown,
                  last_of_frame, input ready);
  modport sink (input valid, channel_index, channel_state, channel_countdown,
                last_of_frame, output ready);
endinterface

FILE: hw/rtl/scsm_cfg_if.sv
interface scsm_cfg_if;
  logic                             valid;
  logic                             ready;
  logic [scsm_pkg::CFG_IDX_W-1:0]   index;
  logic [scsm_pkg::CFG_DATA_W-1:0]  data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

FILE: hw/rtl/scsm_cell.sv
module scsm_cell (
  input  logic                           clk,
  input  logic                           rst_n,
  input  scsm_pkg::cell_ctrl_t           ctrl,
  input  scsm_pkg::offer_t               offer,
  input  logic [scsm_pkg::ST_W-1:0]      nb_st,
  input  logic [scsm_pkg::CD_W-1:0]      nb_cd,
  output logic [scsm_pkg::ST_W-1:0]      st,
  output logic [scsm_pkg::CD_W-1:0]      cd
);

  logic [scsm_pkg::ST_W-1:0] st_r, st_nxt;
  logic [scsm_pkg::CD_W-1:0] cd_r, cd_nxt;

  // Shift in the neighbour's word on flush, else merge the offer when allowed
  always_comb begin
    st_nxt = st_r;
    cd_nxt = cd_r;
    if (ctrl.shift) begin
      st_nxt = nb_st;
      cd_nxt = nb_cd;
    end else if (ctrl.merge &&
                 scsm_pkg::offer_taken(st_r, cd_r, offer.offer_st, offer.secs)) begin
      st_nxt = offer.store_st;
      cd_nxt = offer.secs;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= scsm_pkg::ST_INVALID;
      cd_r <= '0;
    end else begin
      st_r <= st_nxt;
      cd_r <= cd_nxt;
    end
  end

  assign st = st_r;
  assign cd = cd_r;

endmodule

FILE: hw/rtl/scsm_flush_ctrl.sv
module scsm_flush_ctrl #(
  parameter int unsigned CHANNELS = scsm_pkg::CHANNELS_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   flush_start,
  input  logic                   out_ready,
  output scsm_pkg::flush_stat_t  stat
);

  localparam logic [scsm_pkg::IDX_W-1:0] LAST_IDX = scsm_pkg::IDX_W'(CHANNELS - 1);

  scsm_pkg::flush_state_t     state_r, state_nxt;
  logic [scsm_pkg::IDX_W-1:0] cnt_r, cnt_nxt;
  logic                       out_fire;

  assign out_fire = stat.valid && out_ready;

  // Next state: start a run, advance per word taken, stop after the last
  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    case (state_r)
      scsm_pkg::FS_IDLE: begin
        if (flush_start) begin
          state_nxt = scsm_pkg::FS_FLUSH;
          cnt_nxt   = '0;
        end
      end
      scsm_pkg::FS_FLUSH: begin
        if (out_fire) begin
          if (cnt_r == LAST_IDX) begin
            state_nxt = scsm_pkg::FS_IDLE;
          end else begin
            cnt_nxt = cnt_r + 1'b1;
          end
        end
      end
      default: state_nxt = scsm_pkg::FS_IDLE;
    endcase
  end

  // Outputs
  always_comb begin
    stat.busy  = (state_r == scsm_pkg::FS_FLUSH);
    stat.valid = (state_r == scsm_pkg::FS_FLUSH);
    stat.last  = (cnt_r == LAST_IDX);
    stat.index = cnt_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= scsm_pkg::FS_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

endmodule

FILE: hw/rtl/signal_channel_state_merge.sv
// Merge: one word per cycle, back to back while no flush run holds off the input; the
//   cells hold the result in the next cycle.
// Flush: CHANNELS words from the next cycle on, one per cycle while the sink takes them,
//   set by the cell chain shifting one place per word; no input taken then.
// Reset (rst_n low, synchronous): all channels invalid with zero countdown, registers zero.
`include "signal_channel_state_merge_defines.svh"

module signal_channel_state_merge #(
  parameter int unsigned CHANNELS = scsm_pkg::CHANNELS_DEF
) (
  input  logic         clk,
  input  logic         rst_n,
  scsm_in_if.sink      in_bus,
  scsm_out_if.source   out_bus,
  scsm_cfg_if.sink     cfg_bus
);

  logic                            yflash_r;
  logic [scsm_pkg::SECS_W-1:0]     rflash_r;
  scsm_pkg::flush_stat_t           stat;
  scsm_pkg::offer_t                offer;
  logic                            in_fire;
  logic                            flush_go;
  logic                            merge_go;
  logic                            shift;
  logic [scsm_pkg::IDX_W-1:0]      idx_inc;
  logic                            head_clear;
  logic [scsm_pkg::ST_W-1:0]       st_w [CHANNELS+1];
  logic [scsm_pkg::CD_W-1:0]       cd_w [CHANNELS+1];

  // Configuration registers
  assign cfg_bus.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      yflash_r <= 1'b0;
      rflash_r <= '0;
    end else if (cfg_bus.valid) begin
      case (cfg_bus.index)
        scsm_pkg::REG_YELLOW_FLASH: yflash_r <= cfg_bus.data[0];
        scsm_pkg::REG_RED_FLASH:    rflash_r <= cfg_bus.data;
        default: ;
      endcase
    end
  end

  // Input handshake; hold off during a flush run
  assign in_bus.ready = !stat.busy;
  assign in_fire      = in_bus.valid && in_bus.ready;
  assign flush_go     = in_fire && (in_bus.opcode == scsm_pkg::OP_FLUSH);

  // Build the offer and its stored form once for all cells
  always_comb begin
    offer.offer_st = {1'b0, in_bus.lamp_state};
    offer.secs     = in_bus.seconds_left;
    offer.store_st = offer.offer_st;
    if (offer.offer_st == scsm_pkg::ST_YELLOW && yflash_r) begin
      offer.store_st = scsm_pkg::ST_YELLOW_BLINK;
    end else if (offer.offer_st == scsm_pkg::ST_RED &&
                 {{(scsm_pkg::CD_W-scsm_pkg::SECS_W){1'b0}}, rflash_r} >= in_bus.seconds_left)
    begin
      offer.store_st = scsm_pkg::ST_RED_BLINK;
    end
  end

  // Drop offers of invalid or yellow blink
  assign merge_go = in_fire && (in_bus.opcode == scsm_pkg::OP_MERGE) &&
                    (offer.offer_st != scsm_pkg::ST_INVALID) &&
                    (offer.offer_st != scsm_pkg::ST_YELLOW_BLINK);

  scsm_flush_ctrl #(
    .CHANNELS (CHANNELS)
  ) u_flush_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .flush_start (flush_go),
    .out_ready   (out_bus.ready),
    .stat        (stat)
  );

  // Advance the chain one place per word taken; the end feeds in cleared words
  assign shift = stat.valid && out_bus.ready;
  assign st_w[CHANNELS] = scsm_pkg::ST_INVALID;
  assign cd_w[CHANNELS] = '0;

  for (genvar i = 0; i < CHANNELS; i++) begin : g_cell
    scsm_pkg::cell_ctrl_t ctrl;
    assign ctrl.merge = merge_go && in_bus.channel_mask[i];
    assign ctrl.shift = shift;

    scsm_cell u_cell (
      .clk   (clk),
      .rst_n (rst_n),
      .ctrl  (ctrl),
      .offer (offer),
      .nb_st (st_w[i+1]),
      .nb_cd (cd_w[i+1]),
      .st    (st_w[i]),
      .cd    (cd_w[i])
    );
  end

  // Result word comes from the head of the chain
  assign out_bus.valid             = stat.valid;
  assign out_bus.channel_index     = stat.index;
  assign out_bus.channel_state     = st_w[0];
  assign out_bus.channel_countdown = cd_w[0];
  assign out_bus.last_of_frame     = stat.last;

  // Helpers for the checks
  assign idx_inc    = stat.index + 1'b1;
  assign head_clear = (st_w[0] == scsm_pkg::ST_INVALID) && (cd_w[0] == '0);

  // Checks
  `SCSM_ASSERT_ALWAYS(a_in_out_excl, !rst_n || !(in_bus.ready && out_bus.valid))
  `SCSM_ASSERT(a_flush_starts, flush_go |=> (stat.valid && stat.index == '0))
  `SCSM_ASSERT(a_index_steps, (shift && !stat.last) |=> (stat.valid && stat.index == $past(idx_inc)))
  `SCSM_ASSERT(a_frame_cleared, (shift && stat.last) |=> (in_bus.ready && head_clear))

endmodule
